// ===== hw/rtl/swmv_pkg.sv =====
// Shared constants and types for the sliding-window mean/variance core.
package swmv_pkg;

  localparam int WINDOW_MAX  = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int SLOT_W      = $clog2(WINDOW_MAX);
  localparam int COUNT_W     = 9;
  localparam int MEAN_W      = 32;
  localparam int M2_W        = 64;
  localparam int VAR_W       = 48;
  localparam int DIV_W       = 64;
  localparam int STEP_W      = 7;
  localparam int MUL_W       = 32;

  localparam logic [COUNT_W-1:0] WINDOW_RESET = COUNT_W'(16);

  // divide request: dividend is left-aligned so the quotient lands in the low bits
  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [COUNT_W-1:0]  divisor;
    logic [STEP_W-1:0]   steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/swmv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swmv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/swmv_div.sv =====
// Restoring divider, one quotient bit per cycle, narrow divisor.
module swmv_div (
  input  logic              clk,
  input  logic              rst,
  input  swmv_pkg::div_req_t req,
  output swmv_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [swmv_pkg::STEP_W-1:0]   cnt;
  logic [swmv_pkg::DIV_W-1:0]    acc;
  logic [swmv_pkg::COUNT_W-2:0]  rem;
  logic [swmv_pkg::COUNT_W-1:0]  divisor;
  logic [swmv_pkg::COUNT_W-1:0]  rem_sh;
  logic                          fits;

  assign rem_sh = {rem, acc[swmv_pkg::DIV_W-1]};
  assign fits   = (rem_sh >= divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        acc     <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
        cnt     <= req.steps;
        busy    <= 1'b1;
      end else if (busy) begin
        rem <= fits ? (swmv_pkg::COUNT_W-1)'(rem_sh - divisor)
                    : rem_sh[swmv_pkg::COUNT_W-2:0];
        acc <= {acc[swmv_pkg::DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == swmv_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = acc;

endmodule

// ===== hw/rtl/swmv_mul.sv =====
// Registered unsigned 32x32 multiplier shared by the sequencer.
module swmv_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic [swmv_pkg::MUL_W-1:0]     a,
  input  logic [swmv_pkg::MUL_W-1:0]     b,
  output logic [2*swmv_pkg::MUL_W-1:0]   p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

// ===== hw/rtl/sliding_window_mean_variance_core.sv =====
// Sliding-window mean/variance core: sequencer, sample ring, shared divider and multiplier.
//
// Usage notes
//  - Request channel: sample_valid/sample_stall carrying action and sample.
//    action 0 pushes a sample, action 1 clears window and statistics.
//  - Result channel: result_valid/result_stall carrying samples_held,
//    window_mean (Q15.16) and window_variance (16 fraction bits).
//    Exactly one result per request, in order.
//  - config_write/config_data set window_length (0 acts as 1, above 256 as
//    256); a write also clears the store. Write only while idle.
//  - One request at a time: sample_stall stays high from acceptance until the
//    sequencer returns to idle. The result register is loaded as the sequencer
//    leaves its finish state for idle, where the next request can be taken. The
//    shared bit-serial divider runs 33 steps for the mean,
//    41 for the oldest-sample removal and 64 for m2/(count-1).
//  - The result sits in an output register; the next request is taken while
//    it waits. If the receiver stalls and a second result is ready, the
//    sequencer holds in its finish state until the register frees.
//  - Reset (rst, synchronous) empties the window, zeroes mean and m2, sets
//    window_length to 16 and drops result_valid. The ring RAM is not cleared:
//    only slots written since the last clear are ever read.
module sliding_window_mean_variance_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic                                action,
  input  logic signed [swmv_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [swmv_pkg::COUNT_W-1:0]        samples_held,
  output logic signed [swmv_pkg::MEAN_W-1:0]  window_mean,
  output logic [swmv_pkg::VAR_W-1:0]          window_variance,
  input  logic                                config_write,
  input  logic [swmv_pkg::COUNT_W-1:0]        config_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_START,
    ST_RMUL, ST_RDIV, ST_RDIVW, ST_RM2MUL, ST_RM2UPD,
    ST_ADIV, ST_ADIVW, ST_AMUL, ST_AUPD,
    ST_WRITE, ST_VAR, ST_VARW, ST_FINISH
  } state_t;

  state_t state;

  // architectural state
  logic [swmv_pkg::COUNT_W-1:0]       wl;
  logic [swmv_pkg::SLOT_W-1:0]        write_slot;
  logic [swmv_pkg::COUNT_W-1:0]       fill;
  logic signed [swmv_pkg::MEAN_W-1:0] mean;
  logic [swmv_pkg::M2_W-1:0]          m2;

  // working registers for one request
  logic                               act;
  logic signed [31:0]                 x;
  logic signed [31:0]                 o;
  logic signed [32:0]                 d;
  logic signed [31:0]                 nm;
  logic                               neg;
  logic [swmv_pkg::COUNT_W-1:0]       n;
  logic [swmv_pkg::COUNT_W-1:0]       w;
  logic [swmv_pkg::SLOT_W-1:0]        slot;
  logic [swmv_pkg::VAR_W-1:0]         var_r;

  // result register
  logic                               res_valid;
  logic [swmv_pkg::COUNT_W-1:0]       res_held;
  logic signed [swmv_pkg::MEAN_W-1:0] res_mean;
  logic [swmv_pkg::VAR_W-1:0]         res_var;

  // shared units
  swmv_pkg::div_req_t                 div_req;
  swmv_pkg::div_rsp_t                 div_rsp;
  logic                               mul_en;
  logic [swmv_pkg::MUL_W-1:0]         mul_a;
  logic [swmv_pkg::MUL_W-1:0]         mul_b;
  logic [2*swmv_pkg::MUL_W-1:0]       prod;

  logic [swmv_pkg::SAMPLE_BITS-1:0]   ram_rdata;

  // combinational helpers
  logic [swmv_pkg::COUNT_W-1:0]       w_eff;
  logic [swmv_pkg::SLOT_W-1:0]        ws_c;
  logic [31:0]                        mean_mag;
  logic signed [41:0]                 pm;
  logic signed [41:0]                 num;
  logic [41:0]                        num_mag;
  logic signed [32:0]                 rm_a;
  logic signed [32:0]                 rm_b;
  logic signed [32:0]                 add_d;
  logic signed [32:0]                 am_b;
  logic [32:0]                        rm_a_mag;
  logic [32:0]                        rm_b_mag;
  logic [32:0]                        d_mag;
  logic [32:0]                        am_b_mag;
  logic signed [41:0]                 rq_s;
  logic signed [41:0]                 aq_s;
  logic [swmv_pkg::COUNT_W-1:0]       slot_inc;
  logic                               free;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? (33'd0 - v) : v;
  endfunction

  // saturate a wide signed value to the 32-bit mean range
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if ((v[41:31] == '0) || (v[41:31] == '1)) begin
      sat32 = v[31:0];
    end else begin
      sat32 = v[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  endfunction

  // m2 plus or minus a shifted product, clamped at 0 and at all ones
  function automatic logic [63:0] m2_apply(input logic [63:0] acc,
                                           input logic [47:0] p,
                                           input logic        sub);
    logic [64:0] sum;
    sum = {1'b0, acc} + {17'd0, p};
    if (sub) begin
      m2_apply = ({16'd0, p} > acc) ? 64'd0 : (acc - {16'd0, p});
    end else begin
      m2_apply = sum[64] ? {64{1'b1}} : sum[63:0];
    end
  endfunction

  always_comb begin
    if (wl == '0) begin
      w_eff = swmv_pkg::COUNT_W'(1);
    end else if (wl > swmv_pkg::COUNT_W'(swmv_pkg::WINDOW_MAX)) begin
      w_eff = swmv_pkg::COUNT_W'(swmv_pkg::WINDOW_MAX);
    end else begin
      w_eff = wl;
    end
  end

  // slot wraps if a narrower window left it beyond the end
  assign ws_c = ({1'b0, write_slot} >= w_eff) ? '0 : write_slot;

  assign mean_mag = mean[31] ? (32'd0 - mean) : mean;

  // removal: (n*mean - o) rebuilt from the magnitude product
  assign pm      = mean[31] ? -$signed({2'b00, prod[39:0]}) : $signed({2'b00, prod[39:0]});
  assign num     = pm - {{10{o[31]}}, o};
  assign num_mag = num[41] ? (42'd0 - num) : num;
  assign rq_s    = neg ? -$signed({1'b0, div_rsp.quotient[40:0]})
                       : $signed({1'b0, div_rsp.quotient[40:0]});
  assign rm_a    = {o[31], o} - {mean[31], mean};
  assign rm_b    = {o[31], o} - {nm[31], nm};

  // add: d = x - mean, new mean = mean + d/n
  assign add_d   = {x[31], x} - {mean[31], mean};
  assign aq_s    = {{10{mean[31]}}, mean}
                 + (neg ? -$signed({9'd0, div_rsp.quotient[32:0]})
                        : $signed({9'd0, div_rsp.quotient[32:0]}));
  assign am_b    = {x[31], x} - {nm[31], nm};

  // multiplier operand magnitudes (each below 2^32)
  assign rm_a_mag = mag33(rm_a);
  assign rm_b_mag = mag33(rm_b);
  assign d_mag    = mag33(d);
  assign am_b_mag = mag33(am_b);

  assign slot_inc = {1'b0, slot} + 1'b1;
  assign free     = !res_valid || !result_stall;

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_RMUL: begin
        mul_en = 1'b1;
        mul_a  = mean_mag;
        mul_b  = swmv_pkg::MUL_W'(n);
      end
      ST_RM2MUL: begin
        mul_en = 1'b1;
        mul_a  = rm_a_mag[31:0];
        mul_b  = rm_b_mag[31:0];
      end
      ST_AMUL: begin
        mul_en = 1'b1;
        mul_a  = d_mag[31:0];
        mul_b  = am_b_mag[31:0];
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // shared divider request
  always_comb begin
    div_req = '0;
    case (state)
      ST_RDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {num_mag[40:0], 23'd0};
        div_req.divisor  = n - 1'b1;
        div_req.steps    = swmv_pkg::STEP_W'(41);
      end
      ST_ADIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {mag33(add_d), 31'd0};
        div_req.divisor  = n;
        div_req.steps    = swmv_pkg::STEP_W'(33);
      end
      ST_VAR: begin
        div_req.start    = (fill >= swmv_pkg::COUNT_W'(2));
        div_req.dividend = m2;
        div_req.divisor  = fill - 1'b1;
        div_req.steps    = swmv_pkg::STEP_W'(64);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  swmv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  swmv_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  swmv_ram #(
    .WIDTH (swmv_pkg::SAMPLE_BITS),
    .DEPTH (swmv_pkg::WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_WRITE),
    .waddr (slot),
    .wdata (x[31:16]),
    .raddr (ws_c),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wl         <= swmv_pkg::WINDOW_RESET;
      write_slot <= '0;
      fill       <= '0;
      mean       <= '0;
      m2         <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (state == ST_FINISH && free) begin
        res_valid <= 1'b1;
        res_held  <= fill;
        res_mean  <= (fill != '0) ? mean : '0;
        res_var   <= var_r;
      end else if (!result_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (config_write) begin
            wl         <= config_data;
            write_slot <= '0;
            fill       <= '0;
            mean       <= '0;
            m2         <= '0;
          end
          if (sample_valid) begin
            act   <= action;
            x     <= {sample, {swmv_pkg::FRAC_BITS{1'b0}}};
            state <= ST_START;
          end
        end
        ST_START: begin
          w    <= w_eff;
          slot <= ws_c;
          if (act) begin
            write_slot <= '0;
            fill       <= '0;
            mean       <= '0;
            m2         <= '0;
            state      <= ST_VAR;
          end else if (fill >= w_eff) begin
            fill <= w_eff;
            if (w_eff == swmv_pkg::COUNT_W'(1)) begin
              // single-sample window: mean is the sample, no spread
              mean  <= x;
              m2    <= '0;
              state <= ST_WRITE;
            end else begin
              n     <= w_eff;
              state <= ST_RMUL;
            end
          end else begin
            fill  <= fill + 1'b1;
            n     <= fill + 1'b1;
            state <= ST_ADIV;
          end
        end
        ST_RMUL: begin
          o     <= {ram_rdata, {swmv_pkg::FRAC_BITS{1'b0}}};
          state <= ST_RDIV;
        end
        ST_RDIV: begin
          neg   <= num[41];
          state <= ST_RDIVW;
        end
        ST_RDIVW: begin
          if (div_rsp.done) begin
            nm    <= sat32(rq_s);
            state <= ST_RM2MUL;
          end
        end
        ST_RM2MUL: begin
          // removal subtracts, so the sum goes down when the signs agree
          neg   <= (rm_a[32] == rm_b[32]);
          state <= ST_RM2UPD;
        end
        ST_RM2UPD: begin
          m2    <= m2_apply(m2, prod[63:16], neg);
          mean  <= nm;
          state <= ST_ADIV;
        end
        ST_ADIV: begin
          d     <= add_d;
          neg   <= add_d[32];
          state <= ST_ADIVW;
        end
        ST_ADIVW: begin
          if (div_rsp.done) begin
            nm    <= sat32(aq_s);
            state <= ST_AMUL;
          end
        end
        ST_AMUL: begin
          neg   <= (d[32] != am_b[32]);
          state <= ST_AUPD;
        end
        ST_AUPD: begin
          m2    <= m2_apply(m2, prod[63:16], neg);
          mean  <= nm;
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          write_slot <= (slot_inc == w) ? '0 : slot_inc[swmv_pkg::SLOT_W-1:0];
          state      <= ST_VAR;
        end
        ST_VAR: begin
          if (fill >= swmv_pkg::COUNT_W'(2)) begin
            state <= ST_VARW;
          end else begin
            var_r <= '0;
            state <= ST_FINISH;
          end
        end
        ST_VARW: begin
          if (div_rsp.done) begin
            var_r <= (div_rsp.quotient[63:48] != '0) ? {swmv_pkg::VAR_W{1'b1}}
                                                      : div_rsp.quotient[47:0];
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign sample_stall    = (state != ST_IDLE);
  assign result_valid    = res_valid;
  assign samples_held    = res_held;
  assign window_mean     = res_mean;
  assign window_variance = res_var;

endmodule
